FILE: rtl/rkg_pkg.sv
// Shared constants, types and helpers for the key and gain frame receiver.
`timescale 1ns / 1ps

package rkg_pkg;

  // Frame header bytes
  localparam logic [7:0] HDR_KEY     = 8'h80;
  localparam logic [7:0] HDR_GAIN_WR = 8'hA0;
  localparam logic [7:0] HDR_GAIN_RD = 8'hA1;

  // Expected-length value meaning "end not known yet"
  localparam logic [3:0] NO_END = 4'hF;

  // Key frame layout: seven data slots of seven key bits each
  localparam int KEY_SLOTS  = 7;
  localparam int KEY_SLOT_W = 7;
  localparam int GATHER_W   = KEY_SLOTS * KEY_SLOT_W;

  // Gain frame byte slots seen by the value assembly (frame length <= 15)
  localparam int GAIN_SLOTS = 16;

  // Frame record queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Result kinds
  localparam logic FT_KEY  = 1'b0;
  localparam logic FT_GAIN = 1'b1;

  // Gain frame result fields
  typedef struct packed {
    logic        wr;
    logic [7:0]  group;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [63:0] value;
  } gain_info_t;

  localparam int GAIN_INFO_W = $bits(gain_info_t);

  // Bit count of one byte (pairwise folding)
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [7:0] a;
    logic [7:0] c;
    logic [7:0] d;
    a = v - ((v >> 1) & 8'h55);
    c = (a & 8'h33) + ((a >> 2) & 8'h33);
    d = (c + (c >> 4)) & 8'h0f;
    return d[3:0];
  endfunction

endpackage

FILE: rtl/remote_key_and_gain_frame_receiver_top.sv
// Top level of the serial key and gain frame receiver.
`timescale 1ns / 1ps

// Takes one serial byte per cycle and reports each completed frame as one
// result item. A key frame (0x80, presence mask, one byte per set mask bit)
// yields pressed, rising-edge and toggle key bits; a gain frame (0xA0 or
// 0xA1 plus further bytes up to GAIN_FRAME_BYTES) yields three index bytes
// and a big-endian 64-bit value. A byte is taken in the cycle it is offered
// while the record queue has room. The result of a frame enters the record
// queue at the edge that takes the frame's last byte; it enters the output
// register, raising out_tvalid, once that register is empty or out_tready is
// high. A two-entry record queue sits between parser and output, so in_tready
// drops only when the output register and both queue entries hold results
// that out_tready low keeps back. Otherwise the rate is one byte per clock.
module remote_key_and_gain_frame_receiver_top #(
  parameter int KEY_COUNT        = 48,
  parameter int GAIN_FRAME_BYTES = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // rx_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // keys_pressed, keys_rising, keys_toggled, gain_write, gain_group,
  // gain_row, gain_column, gain_value, debug_request, zero fill
  output logic [((3*KEY_COUNT+90+7)/8)*8-1:0] out_tdata,
  output logic                 out_tuser   // frame_type
);

  localparam int OUT_W = ((3*KEY_COUNT + 90 + 7) / 8) * 8;
  localparam int OUT_BITS = 3*KEY_COUNT + 90;
  localparam int REC_W = 1 + KEY_COUNT + rkg_pkg::GAIN_INFO_W;

  logic                 queue_full;
  logic                 rec_push;
  logic                 rec_type;
  logic [KEY_COUNT-1:0] rec_keys;
  rkg_pkg::gain_info_t  rec_gain;

  logic                 q_valid;
  logic                 q_pop;
  logic [REC_W-1:0]     q_data;
  logic                 q_type;
  logic [KEY_COUNT-1:0] q_keys;
  rkg_pkg::gain_info_t  q_gain;

  logic                 out_type;
  logic [KEY_COUNT-1:0] out_pressed, out_rising, out_toggled;
  rkg_pkg::gain_info_t  out_gain;

  rkg_front #(
    .KEY_COUNT        (KEY_COUNT),
    .GAIN_FRAME_BYTES (GAIN_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .queue_full (queue_full),
    .rec_push   (rec_push),
    .rec_type   (rec_type),
    .rec_keys   (rec_keys),
    .rec_gain   (rec_gain)
  );

  rkg_fifo #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data ({rec_type, rec_keys, rec_gain}),
    .full      (queue_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  assign {q_type, q_keys, q_gain} = q_data;

  rkg_back #(
    .KEY_COUNT (KEY_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec_valid   (q_valid),
    .rec_pop     (q_pop),
    .rec_type    (q_type),
    .rec_keys    (q_keys),
    .rec_gain    (q_gain),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_type    (out_type),
    .out_pressed (out_pressed),
    .out_rising  (out_rising),
    .out_toggled (out_toggled),
    .out_gain    (out_gain)
  );

  // Result packing, first field in the low bits
  logic [OUT_BITS-1:0] packed_fields;

  assign packed_fields = {
    (out_type == rkg_pkg::FT_GAIN),
    out_gain.value,
    out_gain.column,
    out_gain.row,
    out_gain.group,
    out_gain.wr,
    out_toggled,
    out_rising,
    out_pressed
  };

  assign out_tdata = OUT_W'(packed_fields);
  assign out_tuser = out_type;

endmodule

FILE: rtl/rkg_front.sv
// Front end: byte parser that tracks frame position and builds frame records.
`timescale 1ns / 1ps

module rkg_front #(
  parameter int KEY_COUNT        = 48,
  parameter int GAIN_FRAME_BYTES = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,
  input  logic                      queue_full,
  output logic                      rec_push,
  output logic                      rec_type,
  output logic [KEY_COUNT-1:0]      rec_keys,
  output rkg_pkg::gain_info_t       rec_gain
);

  typedef enum logic [1:0] {MODE_IDLE, MODE_KEY, MODE_GAIN} mode_t;

  localparam int BUF_W  = 8 * (GAIN_FRAME_BYTES - 1);
  localparam int PAD_W  = 8 * (rkg_pkg::GAIN_SLOTS - GAIN_FRAME_BYTES);
  localparam int SLOT_W = 8 * rkg_pkg::GAIN_SLOTS;

  mode_t                      mode_r, mode_nxt;
  logic [3:0]                 pos_r, pos_nxt;
  logic [3:0]                 exp_r, exp_nxt;
  logic [rkg_pkg::KEY_SLOTS-1:0] rem_r, rem_nxt;
  logic [rkg_pkg::GATHER_W-1:0]  gather_r, gather_nxt;
  logic [BUF_W-1:0]           buf_r, buf_nxt;

  logic                       accept;
  logic [7:0]                 b;
  mode_t                      mode_eff;
  logic [3:0]                 exp_eff;
  logic [3:0]                 ones;
  logic [rkg_pkg::KEY_SLOTS-1:0] rem_cur;
  logic [rkg_pkg::GATHER_W-1:0]  gather_cur;
  logic                       found;
  logic [SLOT_W-1:0]          frame_bytes;
  logic [63:0]                value;

  assign in_tready = ~queue_full;
  assign accept    = in_tvalid & in_tready;
  assign b         = in_tdata;
  assign ones      = rkg_pkg::popcount8(b);

  // Gain frame bytes, frame byte 0 in the top slot, missing tail bytes zero
  assign frame_bytes = {buf_r, b, {PAD_W{1'b0}}};

  always_comb begin
    value = '0;
    for (int j = 4; j < 12; j++) begin
      value = {value[55:0], frame_bytes[8*(rkg_pkg::GAIN_SLOTS-1-j) +: 8]};
    end
  end

  // Parser next state
  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    exp_nxt    = exp_r;
    rem_nxt    = rem_r;
    gather_nxt = gather_r;
    buf_nxt    = buf_r;
    rec_push   = 1'b0;
    rec_type   = rkg_pkg::FT_KEY;
    rec_keys   = '0;
    rec_gain   = '0;
    mode_eff   = mode_r;
    exp_eff    = exp_r;
    found      = 1'b0;
    rem_cur    = (pos_r == 4'd0) ? '0 : rem_r;
    gather_cur = (pos_r == 4'd0) ? '0 : gather_r;

    if (accept) begin
      // Header detection at frame start; other bytes continue the last type
      if (pos_r == 4'd0) begin
        if (b == rkg_pkg::HDR_KEY) begin
          mode_eff = MODE_KEY;
        end else if (b == rkg_pkg::HDR_GAIN_WR || b == rkg_pkg::HDR_GAIN_RD) begin
          mode_eff = MODE_GAIN;
        end
      end
      mode_nxt   = mode_eff;
      rem_nxt    = rem_cur;
      gather_nxt = gather_cur;

      case (mode_eff)
        MODE_KEY: begin
          if (pos_r == 4'd1) begin
            rem_nxt = b[rkg_pkg::KEY_SLOTS-1:0];
            exp_eff = ones;
            exp_nxt = ones;
          end else if (pos_r >= 4'd2) begin
            // Data byte goes to the lowest mask slot not yet filled
            for (int i = 0; i < rkg_pkg::KEY_SLOTS; i++) begin
              if (!found && rem_cur[i]) begin
                found = 1'b1;
                rem_nxt[i] = 1'b0;
                gather_nxt[i*rkg_pkg::KEY_SLOT_W +: rkg_pkg::KEY_SLOT_W] =
                  b[rkg_pkg::KEY_SLOT_W-1:0];
              end
            end
          end
          if (pos_r > exp_eff) begin
            rec_push = 1'b1;
            rec_type = rkg_pkg::FT_KEY;
            rec_keys = gather_nxt[KEY_COUNT-1:0];
            exp_nxt  = rkg_pkg::NO_END;
            pos_nxt  = 4'd0;
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
        MODE_GAIN: begin
          buf_nxt = {buf_r[BUF_W-9:0], b};
          if (pos_r == 4'(GAIN_FRAME_BYTES - 1)) begin
            rec_push        = 1'b1;
            rec_type        = rkg_pkg::FT_GAIN;
            rec_gain.wr     = (frame_bytes[SLOT_W-1 -: 8] == rkg_pkg::HDR_GAIN_WR);
            rec_gain.group  = frame_bytes[SLOT_W-9 -: 8];
            rec_gain.row    = frame_bytes[SLOT_W-17 -: 8];
            rec_gain.column = frame_bytes[SLOT_W-25 -: 8];
            rec_gain.value  = value;
            pos_nxt         = 4'd0;
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
        default: begin
          // Idle: bytes outside a frame are dropped
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= 4'd0;
      exp_r    <= rkg_pkg::NO_END;
      rem_r    <= '0;
      gather_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      exp_r    <= exp_nxt;
      rem_r    <= rem_nxt;
      gather_r <= gather_nxt;
    end
    buf_r <= buf_nxt;
  end

  // A gain frame never runs past its fixed length
  a_gain_pos: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_GAIN |-> pos_r < 4'(GAIN_FRAME_BYTES))
    else $error("gain frame position out of range");

  // A key frame ends within header, mask and eight data bytes
  a_key_pos: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_KEY |-> pos_r <= 4'd9)
    else $error("key frame position out of range");

endmodule

FILE: rtl/rkg_fifo.sv
// Short record queue between the parser front end and the result back end.
`timescale 1ns / 1ps

module rkg_fifo #(
  parameter int WIDTH = 138
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = rkg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("record queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("record queue underflow");

endmodule

FILE: rtl/rkg_back.sv
// Back end: key edge and toggle tracking and the result output register.
`timescale 1ns / 1ps

module rkg_back #(
  parameter int KEY_COUNT = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rec_valid,
  output logic                 rec_pop,
  input  logic                 rec_type,
  input  logic [KEY_COUNT-1:0] rec_keys,
  input  rkg_pkg::gain_info_t  rec_gain,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_type,
  output logic [KEY_COUNT-1:0] out_pressed,
  output logic [KEY_COUNT-1:0] out_rising,
  output logic [KEY_COUNT-1:0] out_toggled,
  output rkg_pkg::gain_info_t  out_gain
);

  logic                 valid_r;
  logic                 type_r;
  logic [KEY_COUNT-1:0] pressed_r, rising_r, toggled_r;
  rkg_pkg::gain_info_t  gain_r;
  logic [KEY_COUNT-1:0] prev_r, tog_r;

  logic                 load;
  logic                 is_key;
  logic [KEY_COUNT-1:0] rising;

  assign load    = rec_valid & (~valid_r | out_ready);
  assign rec_pop = load;
  assign is_key  = (rec_type == rkg_pkg::FT_KEY);
  assign rising  = rec_keys & ~prev_r;

  // Key history and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      prev_r  <= '0;
      tog_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
      if (load && is_key) begin
        prev_r <= rec_keys;
        tog_r  <= tog_r ^ rising;
      end
    end
    if (load) begin
      type_r <= rec_type;
      if (is_key) begin
        pressed_r <= rec_keys;
        rising_r  <= rising;
        toggled_r <= tog_r ^ rising;
        gain_r    <= '0;
      end else begin
        pressed_r <= '0;
        rising_r  <= '0;
        toggled_r <= '0;
        gain_r    <= rec_gain;
      end
    end
  end

  assign out_valid   = valid_r;
  assign out_type    = type_r;
  assign out_pressed = pressed_r;
  assign out_rising  = rising_r;
  assign out_toggled = toggled_r;
  assign out_gain    = gain_r;

  // Key history moves only when a key record is taken
  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(load && is_key) |=> $stable(tog_r) && $stable(prev_r))
    else $error("key history changed without a key record");

endmodule
